/* rtl/tts_pkg.sv */
// tts_pkg: shared constants and types for the task table scheduler.
// No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

  localparam int unsigned SLOTS     = 64;
  localparam logic [6:0]  BOOT_SLOT = 7'd64;

  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_READY    = 3'd1;
  localparam logic [2:0] ST_RUNNING  = 3'd2;
  localparam logic [2:0] ST_BLOCKED  = 3'd3;
  localparam logic [2:0] ST_WAITING  = 3'd4;
  localparam logic [2:0] ST_SLEEPING = 3'd5;

  localparam logic [2:0] K_CREATE   = 3'd0;
  localparam logic [2:0] K_SCHEDULE = 3'd1;
  localparam logic [2:0] K_BLOCK    = 3'd2;
  localparam logic [2:0] K_UNBLOCK  = 3'd3;
  localparam logic [2:0] K_SLEEP    = 3'd4;
  localparam logic [2:0] K_WAKEUP   = 3'd5;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;

  localparam logic [0:0] REG_TICK_MS   = 1'd0;
  localparam logic [0:0] REG_IDLE_SLOT = 1'd1;

  localparam logic [9:0] TICK_MS_RST = 10'd10;

  typedef struct packed {
    logic [2:0]  st;
    logic [7:0]  prio;
    logic [31:0] ticks;
  } entry_t;

endpackage

/* rtl/task_table_scheduler.sv */
// task_table_scheduler: slot table in one synchronous memory, scan sequencer,
// serial divider for sleep. Depends on tts_pkg.
`timescale 1ns / 1ps
// Create, wakeup and schedule scan the 64-entry memory; block/unblock read and
// update one slot, then reschedule when the current slot is blocked; sleep runs a
// 32-step divider, then a scan; sleep from boot and other kinds go straight to the result.
// One item in flight; next item taken the cycle after its result is posted.
// Reset: a clearing pass over all 64 slots marks them free; no items are taken
// until it ends. Current slot resets to the boot context.

module task_table_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  kind,
  input  logic [5:0]  task_slot,
  input  logic [7:0]  task_priority,
  input  logic        block_reason,
  input  logic [31:0] sleep_ms,
  input  logic [31:0] now_tick,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [6:0]  running_slot,
  output logic        switched,
  output logic [5:0]  created_slot,
  output logic [6:0]  woken_count
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_CRW   = 4'd6;
  localparam logic [3:0] S_W1    = 4'd7;
  localparam logic [3:0] S_W2    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_SCHED  = 2'd1;
  localparam logic [1:0] OP_WAKE   = 2'd2;

  tts_pkg::entry_t mem [tts_pkg::SLOTS];
  tts_pkg::entry_t rdata, wd;
  logic            we;
  logic [5:0]      wa, ra;

  logic [3:0]  fsm;
  logic [1:0]  op;
  logic [6:0]  cnt;
  logic        rv;
  logic [5:0]  ridx;
  logic [2:0]  k;
  logic [5:0]  slot;
  logic [7:0]  prio;
  logic        reason;
  logic [31:0] q;
  logic [31:0] now;
  logic [9:0]  rem;
  logic [4:0]  dcnt;
  logic [6:0]  cur, prev_cur, nxt;
  logic        found;
  logic [5:0]  fidx;
  tts_pkg::entry_t best_e, idle_e, cur_e, nxt_e, cur_upd, sel_e;
  logic [6:0]  sel_idx;
  logic        sel_empty;
  logic [1:0]  stat;
  logic [6:0]  woken;
  logic [9:0]  tick_ms;
  logic [5:0]  idle;
  logic [9:0]  div;
  logic [10:0] rem_sh;
  logic        rem_ge;
  logic [32:0] tsum;
  logic        wake_hit, take_best;

  assign item_stall = (fsm != S_IDLE);
  assign div        = (tick_ms == 10'd0) ? 10'd1 : tick_ms;
  assign rem_sh     = {rem, q[31]};
  assign rem_ge     = rem_sh >= {1'b0, div};
  assign tsum       = {1'b0, q} + {32'd0, (rem != 10'd0)};
  assign wake_hit   = (rdata.st == tts_pkg::ST_SLEEPING) && (rdata.ticks <= now);
  assign take_best  = (rdata.st == tts_pkg::ST_READY) && ({1'b0, ridx} != cur) &&
                      (!found || (rdata.ticks > best_e.ticks));

  always_comb begin
    cur_upd = cur_e;
    if (cur_e.st == tts_pkg::ST_RUNNING) cur_upd.st = tts_pkg::ST_READY;
    if (cur_e.ticks == 32'd0) cur_upd.ticks = {24'd0, cur_e.prio};
    sel_empty = 1'b0;
    if (found) begin
      sel_idx = {1'b0, fidx};
      sel_e   = best_e;
    end else if (idle_e.st != tts_pkg::ST_FREE) begin
      sel_idx = {1'b0, idle[5:0]};
      sel_e   = ({1'b0, idle[5:0]} == cur) ? cur_upd : idle_e;
    end else begin
      sel_idx   = cur;
      sel_e     = cur_upd;
      sel_empty = 1'b1;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = ridx;
    wd = rdata;
    ra = cnt[5:0];
    case (fsm)
      S_CLEAR: begin
        we = 1'b1;
        wa = cnt[5:0];
        wd = '{st: tts_pkg::ST_FREE, prio: 8'd0, ticks: 32'd0};
      end
      S_RD: begin
        ra = (k == tts_pkg::K_SLEEP) ? cur[5:0] : slot;
      end
      S_CHK: begin
        wa = (k == tts_pkg::K_SLEEP) ? cur[5:0] : slot;
        if (k == tts_pkg::K_SLEEP) begin
          we = 1'b1;
          wd = '{st: tts_pkg::ST_SLEEPING, prio: rdata.prio, ticks: now + q};
        end else if (rdata.st != tts_pkg::ST_FREE) begin
          we = 1'b1;
          if (k == tts_pkg::K_UNBLOCK) wd.st = tts_pkg::ST_READY;
          else wd.st = reason ? tts_pkg::ST_WAITING : tts_pkg::ST_BLOCKED;
        end
      end
      S_SCAN: begin
        if (rv && op == OP_WAKE && wake_hit) begin
          we = 1'b1;
          wd = '{st: tts_pkg::ST_READY, prio: rdata.prio, ticks: 32'd0};
        end
      end
      S_CRW: begin
        we = found;
        wa = fidx;
        wd = '{st: tts_pkg::ST_READY, prio: prio, ticks: {24'd0, prio}};
      end
      S_W1: begin
        we = !cur[6];
        wa = cur[5:0];
        wd = cur_upd;
      end
      S_W2: begin
        we = !nxt[6];
        wa = nxt[5:0];
        wd = nxt_e;
        wd.st = tts_pkg::ST_RUNNING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm          <= S_CLEAR;
      cnt          <= 7'd0;
      rv           <= 1'b0;
      cur          <= tts_pkg::BOOT_SLOT;
      tick_ms      <= tts_pkg::TICK_MS_RST;
      idle         <= 6'd0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tts_pkg::REG_TICK_MS) tick_ms <= cfg_data;
        else idle <= cfg_data[5:0];
      end
      if (result_valid && !result_stall && fsm != S_FIN) result_valid <= 1'b0;
      case (fsm)
        S_CLEAR: begin
          cnt <= cnt + 7'd1;
          if (cnt[5:0] == 6'd63) fsm <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            k        <= kind;
            slot     <= task_slot;
            prio     <= task_priority;
            reason   <= block_reason;
            q        <= sleep_ms;
            now      <= now_tick;
            prev_cur <= cur;
            stat     <= tts_pkg::STAT_OK;
            woken    <= 7'd0;
            fidx     <= 6'd0;
            found    <= 1'b0;
            cnt      <= 7'd0;
            rv       <= 1'b0;
            rem      <= 10'd0;
            dcnt     <= 5'd0;
            case (kind)
              tts_pkg::K_CREATE: begin
                op <= OP_CREATE; fsm <= S_SCAN;
              end
              tts_pkg::K_SCHEDULE: begin
                op <= OP_SCHED; fsm <= S_SCAN;
              end
              tts_pkg::K_BLOCK, tts_pkg::K_UNBLOCK: fsm <= S_RD;
              tts_pkg::K_SLEEP: begin
                if (cur[6]) begin
                  stat <= tts_pkg::STAT_EMPTY; fsm <= S_FIN;
                end else begin
                  fsm <= S_DIV;
                end
              end
              tts_pkg::K_WAKEUP: begin
                op <= OP_WAKE; fsm <= S_SCAN;
              end
              default: fsm <= S_FIN;
            endcase
          end
        end
        S_DIV: begin
          rem  <= rem_ge ? 10'(rem_sh - {1'b0, div}) : rem_sh[9:0];
          q    <= {q[30:0], rem_ge};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) fsm <= S_RD;
        end
        S_RD: begin
          if (k == tts_pkg::K_SLEEP)
            q <= (tsum[31:0] == 32'd0) ? 32'd1 : tsum[31:0];
          fsm <= S_CHK;
        end
        S_CHK: begin
          fsm <= S_FIN;
          if (k != tts_pkg::K_SLEEP && rdata.st == tts_pkg::ST_FREE) begin
            stat <= tts_pkg::STAT_EMPTY;
          end else if (k == tts_pkg::K_SLEEP ||
                       (k == tts_pkg::K_BLOCK && {1'b0, slot} == cur)) begin
            op  <= OP_SCHED;
            fsm <= S_SCAN;
          end
        end
        S_SCAN: begin
          rv   <= !cnt[6];
          ridx <= cnt[5:0];
          if (!cnt[6]) cnt <= cnt + 7'd1;
          if (rv) begin
            case (op)
              OP_CREATE: begin
                if (!found && rdata.st == tts_pkg::ST_FREE) begin
                  found <= 1'b1; fidx <= ridx;
                end
              end
              OP_SCHED: begin
                if (take_best) begin
                  found <= 1'b1; fidx <= ridx; best_e <= rdata;
                end
                if (ridx == idle[5:0]) idle_e <= rdata;
                if ({1'b0, ridx} == cur) cur_e <= rdata;
              end
              default: begin
                if (wake_hit) woken <= woken + 7'd1;
              end
            endcase
            if (ridx == 6'd63) begin
              case (op)
                OP_CREATE: fsm <= S_CRW;
                OP_SCHED:  fsm <= S_W1;
                default:   fsm <= S_FIN;
              endcase
            end
          end
        end
        S_CRW: begin
          if (!found) begin
            stat <= tts_pkg::STAT_NO_FREE; fidx <= 6'd0;
          end
          fsm <= S_FIN;
        end
        S_W1: begin
          nxt   <= sel_idx;
          nxt_e <= sel_e;
          if (sel_empty) stat <= tts_pkg::STAT_EMPTY;
          fsm <= S_W2;
        end
        S_W2: begin
          cur <= nxt;
          fsm <= S_FIN;
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            status       <= stat;
            running_slot <= cur;
            switched     <= (cur != prev_cur);
            created_slot <= (k == tts_pkg::K_CREATE) ? fidx : 6'd0;
            woken_count  <= woken;
            fsm          <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule
